[hdl/svf_pkg.sv]
// Package for the stereo state-variable filter: widths, codes, control word
// layout and the microcode program. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svf_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int STATE_W     = 32;
    localparam int COEF_FRAC   = 24;
    localparam int GAIN_W      = 30;
    localparam int DAMP_W      = 28;
    localparam int INV_W       = 25;
    localparam int COEF_W      = 30;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 30;
    localparam int STATE_FRAC  = STATE_W - 8;
    localparam int SAMPLE_FRAC = SAMPLE_W - 1;
    localparam int CONV_SH     = STATE_FRAC - SAMPLE_FRAC;
    localparam int ALU_W       = STATE_W + 3;
    localparam int PROD_W      = STATE_W + COEF_W + 1;
    localparam int STEPS       = 9;
    localparam int STEP_W      = $clog2(STEPS);

    localparam logic [DAMP_W-1:0] DAMP_RST = DAMP_W'(1) << COEF_FRAC;
    localparam logic [INV_W-1:0]  INV_RST  = INV_W'(1) << COEF_FRAC;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYPASS, MODE_LOWPASS, MODE_BANDPASS, MODE_HIGHPASS
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE, CFG_GAIN, CFG_DAMP, CFG_INV
    } t_cfg_idx;

    // Operand sources of the datapath.
    typedef enum logic [2:0] {
        SRC_ZERO, SRC_V0, SRC_P, SRC_T, SRC_V2, SRC_V3, SRC_IC1, SRC_IC2
    } t_src;

    // Destinations of the adder result.
    typedef enum logic [2:0] {
        DST_NONE, DST_T, DST_V2, DST_V3, DST_IC1, DST_IC2, DST_Y
    } t_dst;

    typedef enum logic [1:0] {CF_K, CF_INV, CF_G} t_coef;

    // Sequencing: step on, or end of a channel (loop once, then finish).
    typedef enum logic {NX_STEP, NX_CHAN} t_next;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    // One control word. The adder computes
    // sat(sat(a or 2a, plus or minus b) - c).
    typedef struct packed {
        logic  mul_en;
        t_src  mul_a;
        t_coef mul_c;
        t_dst  dst;
        t_src  alu_a;
        logic  alu_dbl;
        t_src  alu_b;
        logic  alu_b_neg;
        t_src  alu_c;
        t_next nxt;
    } t_uword;

    typedef struct packed {
        logic   load;
        logic   run;
        logic   ch;
        logic   xfer;
        t_uword uw;
    } t_dp_ctl;

    // Program for one channel; the product register P holds the last product.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            // P = k * ic1
            4'd0: w = '{1'b1, SRC_IC1, CF_K, DST_NONE, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0,
                        SRC_ZERO, NX_STEP};
            // T = v0 - P - ic2
            4'd1: w = '{1'b0, SRC_ZERO, CF_K, DST_T, SRC_V0, 1'b0, SRC_P, 1'b1,
                        SRC_IC2, NX_STEP};
            // P = v1 = T * inv_denom
            4'd2: w = '{1'b1, SRC_T, CF_INV, DST_NONE, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0,
                        SRC_ZERO, NX_STEP};
            // P = g * v1
            4'd3: w = '{1'b1, SRC_P, CF_G, DST_NONE, SRC_ZERO, 1'b0, SRC_ZERO, 1'b0,
                        SRC_ZERO, NX_STEP};
            // v2 = ic1 + P
            4'd4: w = '{1'b0, SRC_ZERO, CF_K, DST_V2, SRC_IC1, 1'b0, SRC_P, 1'b0,
                        SRC_ZERO, NX_STEP};
            // P = g * v2, ic1 = 2*v2 - ic1
            4'd5: w = '{1'b1, SRC_V2, CF_G, DST_IC1, SRC_V2, 1'b1, SRC_IC1, 1'b1,
                        SRC_ZERO, NX_STEP};
            // v3 = ic2 + P
            4'd6: w = '{1'b0, SRC_ZERO, CF_K, DST_V3, SRC_IC2, 1'b0, SRC_P, 1'b0,
                        SRC_ZERO, NX_STEP};
            // P = k * v2, ic2 = 2*v3 - ic2
            4'd7: w = '{1'b1, SRC_V2, CF_K, DST_IC2, SRC_V3, 1'b1, SRC_IC2, 1'b1,
                        SRC_ZERO, NX_STEP};
            // highpass = v0 - P - v3, pick the response, end of channel
            4'd8: w = '{1'b0, SRC_ZERO, CF_K, DST_Y, SRC_V0, 1'b0, SRC_P, 1'b1,
                        SRC_V3, NX_CHAN};
            default: w = '{1'b0, SRC_ZERO, CF_K, DST_NONE, SRC_ZERO, 1'b0, SRC_ZERO,
                           1'b0, SRC_ZERO, NX_CHAN};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/svf_seq.sv]
// Microcode sequencer: state machine, step counter, channel bit, control ROM
// and the stream handshakes. Depends on svf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svf_seq
    import svf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_mode   i_mode,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_ctl      o_ctl
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic                r_ch,    n_ch;
    logic                r_ovalid, n_ovalid;
    logic                w_accept;
    logic                w_xfer;
    t_uword              w_uw;

    assign w_uw     = ucode(r_step);
    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_xfer   = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ch     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_ch     = r_ch;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_step  = '0;
                    n_ch    = 1'b0;
                    n_state = (i_mode == MODE_BYPASS) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (w_uw.nxt == NX_CHAN) begin
                    n_step = '0;
                    if (!r_ch) begin
                        n_ch = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DONE: begin
                if (w_xfer) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_ctl.load = w_accept;
        o_ctl.run  = (r_state == S_RUN);
        o_ctl.ch   = r_ch;
        o_ctl.xfer = w_xfer;
        o_ctl.uw   = w_uw;
    end

endmodule

`default_nettype wire

[hdl/svf_dp.sv]
// Datapath: input and output registers, integrator states, one coefficient
// multiplier and one saturating adder driven by the control word. Uses svf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svf_dp
    import svf_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_dp_ctl                     i_ctl,
    input  wire t_mode                       i_mode,
    input  wire logic [GAIN_W-1:0]           i_gain,
    input  wire logic [DAMP_W-1:0]           i_damp,
    input  wire logic [INV_W-1:0]            i_inv,
    input  wire logic signed [SAMPLE_W-1:0]  i_left,
    input  wire logic signed [SAMPLE_W-1:0]  i_right,
    input  wire logic                        i_last,
    output logic signed [SAMPLE_W-1:0]       o_left,
    output logic signed [SAMPLE_W-1:0]       o_right,
    output logic                             o_last
);

    logic signed [SAMPLE_W-1:0] r_xl, r_xr, r_yl, r_yr, r_ol, r_or;
    logic                       r_last, r_olast;
    logic signed [STATE_W-1:0]  r_p, r_t, r_v2, r_v3;
    logic signed [STATE_W-1:0]  r_ic1 [2];
    logic signed [STATE_W-1:0]  r_ic2 [2];

    logic signed [STATE_W-1:0]  w_v0, w_ic1, w_ic2;
    logic signed [STATE_W-1:0]  w_ma, w_aa, w_ab, w_ac;
    logic [COEF_W-1:0]          w_coef;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [STATE_W-1:0]  w_mres;
    logic signed [ALU_W-1:0]    w_sum1, w_sum2;
    logic signed [STATE_W-1:0]  w_s1, w_ares, w_y;
    logic signed [SAMPLE_W-1:0] w_xs;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [PROD_W-1:0] v);
        logic [PROD_W-STATE_W:0] top;
        top = v[PROD_W-1:STATE_W-1];
        if (top == '0 || top == '1) begin
            return v[STATE_W-1:0];
        end
        return v[PROD_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    // Floor shift to the sample format, then saturate.
    function automatic logic signed [SAMPLE_W-1:0] to_sample(
        input logic signed [STATE_W-1:0] y);
        logic signed [STATE_W-1:0] sh;
        logic [STATE_W-SAMPLE_W:0] top;
        sh  = y >>> CONV_SH;
        top = sh[STATE_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return sh[SAMPLE_W-1:0];
        end
        return sh[STATE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [STATE_W-1:0] pick(
        input t_src s,
        input logic signed [STATE_W-1:0] v0, p, t, v2, v3, ic1, ic2);
        logic signed [STATE_W-1:0] r;
        unique case (s)
            SRC_V0:  r = v0;
            SRC_P:   r = p;
            SRC_T:   r = t;
            SRC_V2:  r = v2;
            SRC_V3:  r = v3;
            SRC_IC1: r = ic1;
            SRC_IC2: r = ic2;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign w_xs  = i_ctl.ch ? r_xr : r_xl;
    assign w_v0  = STATE_W'(w_xs) <<< CONV_SH;
    assign w_ic1 = r_ic1[i_ctl.ch];
    assign w_ic2 = r_ic2[i_ctl.ch];

    assign w_ma = pick(i_ctl.uw.mul_a, w_v0, r_p, r_t, r_v2, r_v3, w_ic1, w_ic2);
    assign w_aa = pick(i_ctl.uw.alu_a, w_v0, r_p, r_t, r_v2, r_v3, w_ic1, w_ic2);
    assign w_ab = pick(i_ctl.uw.alu_b, w_v0, r_p, r_t, r_v2, r_v3, w_ic1, w_ic2);
    assign w_ac = pick(i_ctl.uw.alu_c, w_v0, r_p, r_t, r_v2, r_v3, w_ic1, w_ic2);

    always_comb begin
        unique case (i_ctl.uw.mul_c)
            CF_K:    w_coef = COEF_W'(i_damp);
            CF_INV:  w_coef = COEF_W'(i_inv);
            CF_G:    w_coef = i_gain;
            default: w_coef = '0;
        endcase
    end

    // Floor of value times coefficient over 2^24, saturated.
    assign w_prod = w_ma * $signed({1'b0, w_coef});
    assign w_mres = sat_state(w_prod >>> COEF_FRAC);

    always_comb begin
        w_sum1 = (i_ctl.uw.alu_dbl ? (ALU_W'(w_aa) <<< 1) : ALU_W'(w_aa))
               + (i_ctl.uw.alu_b_neg ? -ALU_W'(w_ab) : ALU_W'(w_ab));
        w_s1   = sat_state(PROD_W'(w_sum1));
        w_sum2 = ALU_W'(w_s1) - ALU_W'(w_ac);
        w_ares = sat_state(PROD_W'(w_sum2));
    end

    always_comb begin
        unique case (i_mode)
            MODE_LOWPASS:  w_y = r_v3;
            MODE_BANDPASS: w_y = r_v2;
            default:       w_y = w_ares;
        endcase
    end

    // Integrator states are architectural and cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic1[0] <= '0;
            r_ic1[1] <= '0;
            r_ic2[0] <= '0;
            r_ic2[1] <= '0;
        end else if (i_ctl.run) begin
            if (i_ctl.uw.dst == DST_IC1) begin
                r_ic1[i_ctl.ch] <= w_ares;
            end
            if (i_ctl.uw.dst == DST_IC2) begin
                r_ic2[i_ctl.ch] <= w_ares;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_xl   <= i_left;
            r_xr   <= i_right;
            r_last <= i_last;
            if (i_mode == MODE_BYPASS) begin
                r_yl <= i_left;
                r_yr <= i_right;
            end
        end
        if (i_ctl.run) begin
            if (i_ctl.uw.mul_en) begin
                r_p <= w_mres;
            end
            case (i_ctl.uw.dst)
                DST_T:  r_t  <= w_ares;
                DST_V2: r_v2 <= w_ares;
                DST_V3: r_v3 <= w_ares;
                DST_Y: begin
                    if (i_ctl.ch) begin
                        r_yr <= to_sample(w_y);
                    end else begin
                        r_yl <= to_sample(w_y);
                    end
                end
                default: ;
            endcase
        end
        if (i_ctl.xfer) begin
            r_ol    <= r_yl;
            r_or    <= r_yr;
            r_olast <= r_last;
        end
    end

    assign o_left  = r_ol;
    assign o_right = r_or;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

[hdl/stereo_state_variable_filter_top.sv]
// Top level of the stereo state-variable filter: configuration registers,
// sequencer and datapath. Depends on svf_pkg, svf_seq and svf_dp.
// Filtering modes: a 9-step program runs on one shared multiplier and adder,
// once per channel. A new item is taken only after the previous result has
// passed to the output register, in bypass as in the filtering modes.
// Reset (synchronous, active low) clears both integrator states per channel,
// the configuration registers to their defaults and all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module stereo_state_variable_filter_top
    import svf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream; tdata from bit 0: left_in[23:0], right_in[47:24].
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [2*SAMPLE_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    // Output stream; tdata from bit 0: left_out[23:0], right_out[47:24].
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [2*SAMPLE_W-1:0]       m_axis_tdata,
    output logic                        m_axis_tlast,
    // Configuration writes: index 0 mode, 1 gain g, 2 damping k, 3 inverse
    // denominator.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_mode               r_mode;
    logic [GAIN_W-1:0]   r_gain;
    logic [DAMP_W-1:0]   r_damp;
    logic [INV_W-1:0]    r_inv;
    t_dp_ctl             w_ctl;
    logic signed [SAMPLE_W-1:0] w_ol, w_or;

    // Configuration is always writable; software is to write it only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BYPASS;
            r_gain <= '0;
            r_damp <= DAMP_RST;
            r_inv  <= INV_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[MODE_W-1:0]);
                CFG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DAMP: r_damp <= i_cfg_data[DAMP_W-1:0];
                CFG_INV:  r_inv  <= i_cfg_data[INV_W-1:0];
                default:  ;
            endcase
        end
    end

    // The sequencer steps the microcode and owns both stream handshakes; the
    // result register in the datapath lets the next item in while a finished
    // result still waits downstream.
    svf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_mode      (r_mode),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctl       (w_ctl)
    );

    svf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_mode  (r_mode),
        .i_gain  (r_gain),
        .i_damp  (r_damp),
        .i_inv   (r_inv),
        .i_left  (s_axis_tdata[SAMPLE_W-1:0]),
        .i_right (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .i_last  (s_axis_tlast),
        .o_left  (w_ol),
        .o_right (w_or),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_or, w_ol};

endmodule

`default_nettype wire

[verif/stereo_state_variable_filter_top_tb.sv]
// Self-checking testbench for stereo_state_variable_filter_top: a fixed-point
// filter predictor, stream drivers with random idling and a result checker.
// Depends on svf_pkg and the RTL of the filter top level.
`timescale 1ns / 1ps

module stereo_state_variable_filter_top_tb;
    import svf_pkg::*;

    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;
    localparam longint COEF_ONE = longint'(1) <<< COEF_FRAC;
    localparam logic [SAMPLE_W-1:0] SMP_POS = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMP_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;
    } filtered_pair_t;

    // Block ports; every input has a known value from time zero.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [2*SAMPLE_W-1:0] s_axis_tdata = '0;   // left[23:0], right[47:24]
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*SAMPLE_W-1:0] m_axis_tdata;        // left[23:0], right[47:24]
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor copy of the registers and of the integrator states.
    t_mode  cur_mode = MODE_BYPASS;
    longint cur_gain = 0;
    longint cur_damp = COEF_ONE;
    longint cur_inv = COEF_ONE;
    longint integ1 [2] = '{0, 0};
    longint integ2 [2] = '{0, 0};

    filtered_pair_t expected_pairs [$];
    int error_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;     // chance per item that the sender idles first
    int recv_stall_pct = 0;   // chance per cycle that the receiver starts a stall
    int hold_request = 0;     // one long receiver stall, in cycles

    stereo_state_variable_filter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point filter predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_state(longint v);
        if (v > STATE_MAX) return STATE_MAX;
        if (v < STATE_MIN) return STATE_MIN;
        return v;
    endfunction

    // Coefficient product, floored at the 24 fraction bits, then saturated.
    function automatic longint scale_by_coef(longint a, longint c);
        return clamp_state((a * c) >>> COEF_FRAC);
    endfunction

    // One channel of the trapezoidal filter; updates that channel's states.
    function automatic logic [SAMPLE_W-1:0] filter_channel(int ch, logic [SAMPLE_W-1:0] x);
        longint ic1, ic2, v0, t, v1, v2, v3, y, r;
        ic1 = integ1[ch];
        ic2 = integ2[ch];
        v0 = clamp_state(longint'($signed(x)) * (longint'(1) <<< CONV_SH));
        t = clamp_state(clamp_state(v0 - scale_by_coef(ic1, cur_damp)) - ic2);
        v1 = scale_by_coef(t, cur_inv);
        v2 = clamp_state(ic1 + scale_by_coef(v1, cur_gain));
        v3 = clamp_state(ic2 + scale_by_coef(v2, cur_gain));
        integ1[ch] = clamp_state(2 * v2 - ic1);
        integ2[ch] = clamp_state(2 * v3 - ic2);
        case (cur_mode)
            MODE_LOWPASS:  y = v3;
            MODE_BANDPASS: y = v2;
            default:       y = clamp_state(clamp_state(v0 - scale_by_coef(v2, cur_damp)) - v3);
        endcase
        r = y >>> CONV_SH;
        if (r > SMP_MAX) r = SMP_MAX;
        if (r < SMP_MIN) r = SMP_MIN;
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic filtered_pair_t predict_pair(logic [SAMPLE_W-1:0] l,
                                                    logic [SAMPLE_W-1:0] r, logic last);
        filtered_pair_t p;
        if (cur_mode == MODE_BYPASS) begin
            p.left = l;
            p.right = r;
        end else begin
            p.left = filter_channel(0, l);
            p.right = filter_channel(1, r);
        end
        p.last = last;
        return p;
    endfunction

    // Reciprocal of 1 + g*(g+k), as software would load it.
    function automatic longint inv_for(longint g, longint k);
        return (COEF_ONE * COEF_ONE) / (COEF_ONE + ((g * (g + k)) >>> COEF_FRAC));
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic compare_field(string name, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
        if (got !== want)
            flag_error($sformatf("%s mismatch: expected %0d, got %0d",
                                 name, $signed(want), $signed(got)));
    endtask

    always @(posedge i_clk) begin
        filtered_pair_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pairs.size() == 0) begin
                flag_error($sformatf("unexpected result item: left %0d right %0d last %0b",
                                     $signed(m_axis_tdata[SAMPLE_W-1:0]),
                                     $signed(m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
                                     m_axis_tlast));
            end else begin
                want = expected_pairs.pop_front();
                compare_field("left_out", want.left, m_axis_tdata[SAMPLE_W-1:0]);
                compare_field("right_out", want.right, m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
                compare_field("last_out", SAMPLE_W'(want.last), SAMPLE_W'(m_axis_tlast));
            end
        end
    end

    // The run is bounded by a cycle count in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stereo_state_variable_filter_top regression: fail");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long stall when a test asks for it.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && recv_stall_pct > 0 &&
                         $urandom_range(0, 99) < recv_stall_pct) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Leaves the valid high on return, so a following write can go back to back.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE: cur_mode = t_mode'(val[MODE_W-1:0]);
            CFG_GAIN: cur_gain = longint'(val[GAIN_W-1:0]);
            CFG_DAMP: cur_damp = longint'(val[DAMP_W-1:0]);
            CFG_INV:  cur_inv = longint'(val[INV_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic program_filter(logic [CFG_DATA_W-1:0] mode, logic [CFG_DATA_W-1:0] g,
                                  logic [CFG_DATA_W-1:0] k, logic [CFG_DATA_W-1:0] inv);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DAMP, k);
        write_reg(CFG_INV, inv);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one stereo item and records its expected result once accepted.
    // The valid stays high afterwards unless the next call idles first.
    task automatic send_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic last);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, l};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pairs.push_back(predict_pair(l, r, last));
    endtask

    // Ends a burst of items and waits until every result has come back.
    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_POS;
            1: return SMP_NEG;
            2: return SAMPLE_W'($signed($urandom_range(0, 8191)) - 4096);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic stream_pairs(int n);
        repeat (n) send_pair(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
        finish_burst();
    endtask

    // Mostly stable tunings with a matching reciprocal; sometimes raw register
    // values, upper data bits included, to drive the saturation paths.
    task automatic choose_settings(bit force_filter);
        longint g, k;
        logic [CFG_DATA_W-1:0] mode;
        mode = force_filter ? CFG_DATA_W'($urandom_range(1, 3)) : CFG_DATA_W'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) begin
            if (force_filter && mode[MODE_W-1:0] == 0) mode = CFG_DATA_W'(MODE_HIGHPASS);
            program_filter(CFG_DATA_W'(mode | ($urandom() & ~CFG_DATA_W'(3))),
                           CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                           CFG_DATA_W'($urandom()));
        end else begin
            g = longint'($urandom_range(0, 1 << 25));
            k = longint'($urandom_range(0, 167772160));
            program_filter(mode, CFG_DATA_W'(g), CFG_DATA_W'(k), CFG_DATA_W'(inv_for(g, k)));
        end
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 45;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the block is in bypass: items come back unchanged.
    task automatic test_reset_bypass();
        send_pair(SMP_POS, SMP_POS, 1'b0);
        send_pair(SMP_NEG, SMP_NEG, 1'b1);
        send_pair('0, '1, 1'b0);
        send_pair(SAMPLE_W'(1), SMP_NEG, 1'b1);
        finish_burst();
    endtask

    // Only the mode is written, so the reset values of g, k and the reciprocal apply.
    task automatic test_reset_coefficients();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_HIGHPASS));
        i_cfg_valid <= 1'b0;
        send_pair(SMP_POS, SMP_NEG, 1'b0);
        send_pair(SMP_NEG, SMP_POS, 1'b1);
        send_pair('0, SAMPLE_W'(1), 1'b0);
        finish_burst();
    endtask

    task automatic test_each_mode();
        longint g, k;
        g = COEF_ONE / 4;
        k = COEF_ONE;
        program_filter(CFG_DATA_W'(MODE_LOWPASS), CFG_DATA_W'(g), CFG_DATA_W'(k),
                       CFG_DATA_W'(inv_for(g, k)));
        send_pair(SMP_POS, SMP_NEG, 1'b0);
        send_pair(SMP_POS, SMP_NEG, 1'b1);
        finish_burst();
        program_filter(CFG_DATA_W'(MODE_BANDPASS), CFG_DATA_W'(g), CFG_DATA_W'(k),
                       CFG_DATA_W'(inv_for(g, k)));
        send_pair(SMP_NEG, SMP_POS, 1'b0);
        send_pair('0, '0, 1'b1);
        finish_burst();
        program_filter(CFG_DATA_W'(MODE_HIGHPASS), CFG_DATA_W'(g), CFG_DATA_W'(k),
                       CFG_DATA_W'(inv_for(g, k)));
        send_pair(SMP_POS, SAMPLE_W'(1), 1'b1);
        send_pair(SMP_NEG, '1, 1'b0);
        finish_burst();
    endtask

    // Coefficients at zero, at their nominal maxima and at the full register widths.
    task automatic test_coef_extremes();
        program_filter(CFG_DATA_W'(MODE_HIGHPASS), {GAIN_W{1'b1}},
                       CFG_DATA_W'({DAMP_W{1'b1}}), CFG_DATA_W'({INV_W{1'b1}}));
        send_pair(SMP_POS, SMP_NEG, 1'b0);
        send_pair(SMP_NEG, SMP_POS, 1'b1);
        finish_burst();
        program_filter(CFG_DATA_W'(MODE_BANDPASS), '0, '0, '0);
        send_pair(SMP_POS, SMP_NEG, 1'b1);
        send_pair(SMP_NEG, SMP_POS, 1'b0);
        finish_burst();
        program_filter(CFG_DATA_W'(MODE_LOWPASS), CFG_DATA_W'(1) << 29,
                       CFG_DATA_W'(167772160), CFG_DATA_W'(COEF_ONE));
        send_pair(SMP_POS, SMP_POS, 1'b0);
        send_pair(SMP_NEG, SMP_NEG, 1'b1);
        finish_burst();
    endtask

    // A long receiver stall fills the block while the sender keeps offering items;
    // then the sender waits for every result before it resumes.
    task automatic test_backpressure();
        longint g, k;
        g = COEF_ONE / 8;
        k = COEF_ONE / 2;
        program_filter(CFG_DATA_W'(MODE_LOWPASS), CFG_DATA_W'(g), CFG_DATA_W'(k),
                       CFG_DATA_W'(inv_for(g, k)));
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_request = 300;
        stream_pairs(30);
        stream_pairs(20);
        program_filter(CFG_DATA_W'(MODE_BYPASS), CFG_DATA_W'(g), CFG_DATA_W'(k),
                       CFG_DATA_W'(inv_for(g, k)));
        hold_request = 100;
        stream_pairs(10);
    endtask

    task automatic test_random_settings(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            choose_settings(1'b0);
            send_gap_pct = pick_idle_pct();
            recv_stall_pct = pick_idle_pct();
            len = $urandom_range(10, 80);
            stream_pairs(len);
            sent += len;
        end
    endtask

    // The closing stretch runs at full rate on both sides.
    task automatic test_steady_stream();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        choose_settings(1'b1);
        stream_pairs(150);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_bypass();
        test_reset_coefficients();
        test_each_mode();
        test_coef_extremes();
        test_backpressure();
        test_random_settings(1700);
        test_steady_stream();
        // Let any stray result show up before deciding.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_pairs.size() == 0)
            $display("stereo_state_variable_filter_top regression: pass");
        else
            $display("stereo_state_variable_filter_top regression: fail");
        $finish;
    end

endmodule
